### src/dtrc_pkg.sv
// shared constants, codes and widths for the device table with response check
package dtrc_pkg;

    // field widths
    localparam int ACTION_W    = 2;
    localparam int MAC_W       = 48;
    localparam int WORD_W      = 64;
    localparam int RESP_W      = 4 * WORD_W;
    localparam int STATUS_W    = 3;
    localparam int ONES_W      = 9;
    localparam int IDX_OUT_W   = 4;
    localparam int CNT_OUT_W   = 5;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 9;

    // popcount slice handled per cycle
    localparam int POP_W     = 32;
    localparam int POP_CNT_W = $clog2(POP_W + 1);
    localparam int POP_STEPS = RESP_W / POP_W;

    // defaults
    localparam int TABLE_DEPTH_DEF = 16;
    localparam logic [ONES_W-1:0] MIN_ONES_RST = ONES_W'(77);
    localparam logic [ONES_W-1:0] MAX_ONES_RST = ONES_W'(179);

    // request codes
    localparam logic [ACTION_W-1:0] ACT_ENROLL = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DEACT  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_VERIFY = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADONES   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_INACTIVE  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BADACTION = 3'd6;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_ONES = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ONES = 1'b1;

    // ones in one nibble
    function automatic logic [2:0] nib_pop(input logic [3:0] v);
        nib_pop = 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
    endfunction

    // ones in one slice, summed nibble by nibble
    function automatic logic [POP_CNT_W-1:0] slice_pop(input logic [POP_W-1:0] v);
        logic [POP_CNT_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < POP_W / 4; i++) begin
            acc = acc + POP_CNT_W'(nib_pop(v[4*i +: 4]));
        end
        slice_pop = acc;
    endfunction

endpackage

### src/device_table_with_response_check.sv
// device table with response check: sequencer, popcount unit and table scan
// enroll and deactivate scan the table entries before they give a result
//   (one table entry compared per cycle through the ram read port)
// verify first counts ones: the popcount unit takes 32 response bits per cycle, then a bounds check
// an unknown action goes straight to its result without a scan; one request at a time,
//   the next one taken the cycle after the result is loaded into the output register
// reset (synchronous, active low) empties the table, clears all active marks and
//   restores min_ones 77 and max_ones 179; identifier storage is not cleared
module device_table_with_response_check #(
    parameter int TABLE_DEPTH = dtrc_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [dtrc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [dtrc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [dtrc_pkg::ACTION_W-1:0]    i_action,
    input  logic [dtrc_pkg::MAC_W-1:0]       i_device_mac,
    input  logic [dtrc_pkg::WORD_W-1:0]      i_response_word0,
    input  logic [dtrc_pkg::WORD_W-1:0]      i_response_word1,
    input  logic [dtrc_pkg::WORD_W-1:0]      i_response_word2,
    input  logic [dtrc_pkg::WORD_W-1:0]      i_response_word3,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [dtrc_pkg::STATUS_W-1:0]    o_status,
    output logic [dtrc_pkg::ONES_W-1:0]      o_ones_count,
    output logic [dtrc_pkg::IDX_OUT_W-1:0]   o_entry_index,
    output logic [dtrc_pkg::CNT_OUT_W-1:0]   o_enrolled_count
);

    import dtrc_pkg::*;

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int STEP_W = $clog2(POP_STEPS);
    localparam logic [CNT_W-1:0]  DEPTH_C   = CNT_W'(TABLE_DEPTH);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(POP_STEPS - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ONES = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]             r_state;
    logic [ACTION_W-1:0]    r_action;
    logic [MAC_W-1:0]       r_mac;
    logic [RESP_W-1:0]      r_resp;
    logic [STEP_W-1:0]      r_step;
    logic [ONES_W-1:0]      r_ones;
    logic [ONES_W-1:0]      r_min;
    logic [ONES_W-1:0]      r_max;
    logic [CNT_W-1:0]       r_total;
    logic [TABLE_DEPTH-1:0] r_active;
    logic [CNT_W-1:0]       r_rd_idx;
    logic                   r_rd_vld;
    logic [IDX_W-1:0]       r_cmp_idx;
    logic [STATUS_W-1:0]    r_res_status;
    logic [IDX_W-1:0]       r_res_idx;
    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_out_status;
    logic [ONES_W-1:0]      r_out_ones;
    logic [IDX_OUT_W-1:0]   r_out_idx;
    logic [CNT_OUT_W-1:0]   r_out_cnt;

    logic [MAC_W-1:0]           ram_rdata;
    logic                       ram_we;
    logic                       ram_re;
    logic                       match;
    logic                       scan_end;
    logic                       out_load;
    logic [IDX_W+IDX_OUT_W-1:0] idx_ext;
    logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

    // identifier store
    dtrc_ram #(
        .WIDTH (MAC_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (IDX_W)
    ) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_total[IDX_W-1:0]),
        .i_wdata (r_mac),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // scan control: compare last read entry, issue next read
    assign match    = r_rd_vld && (ram_rdata == r_mac);
    assign scan_end = !match && (r_rd_idx >= r_total);
    assign ram_re   = (r_state == S_SCAN) && !match && !scan_end;
    assign ram_we   = (r_state == S_SCAN) && scan_end && (r_action == ACT_ENROLL)
                      && (r_total < DEPTH_C);

    // output register loads when a result is ready and the register is free or its result is taken
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // result width adjustment
    assign idx_ext = {{IDX_OUT_W{1'b0}}, r_res_idx};
    assign cnt_ext = {{CNT_OUT_W{1'b0}}, r_total};

    // sequencer and table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_active    <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_min       <= MIN_ONES_RST;
            r_max       <= MAX_ONES_RST;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MIN_ONES: r_min <= i_cfg_data;
                    CFG_MAX_ONES: r_max <= i_cfg_data;
                    default: ;
                endcase
            end

            // result transaction loaded or taken
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_action  <= i_action;
                        r_mac     <= i_device_mac;
                        r_resp    <= {i_response_word3, i_response_word2,
                                      i_response_word1, i_response_word0};
                        r_ones    <= '0;
                        r_step    <= '0;
                        r_rd_idx  <= '0;
                        r_rd_vld  <= 1'b0;
                        r_res_idx <= '0;
                        case (i_action)
                            ACT_VERIFY: begin
                                r_res_status <= ST_OK;
                                r_state      <= S_ONES;
                            end
                            ACT_ENROLL: begin
                                r_res_status <= ST_OK;
                                r_state      <= S_SCAN;
                            end
                            ACT_DEACT: begin
                                r_res_status <= ST_OK;
                                r_state      <= S_SCAN;
                            end
                            default: begin
                                r_res_status <= ST_BADACTION;
                                r_state      <= S_DONE;
                            end
                        endcase
                    end
                end
                // popcount one slice per cycle
                S_ONES: begin
                    r_ones <= r_ones + ONES_W'(slice_pop(r_resp[POP_W-1:0]));
                    r_resp <= r_resp >> POP_W;
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_STEP) begin
                        r_state <= S_CHK;
                    end
                end
                // bounds check on the ones count
                S_CHK: begin
                    if ((r_ones < r_min) || (r_ones > r_max)) begin
                        r_res_status <= ST_BADONES;
                        r_state      <= S_DONE;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                // one entry compared per cycle
                S_SCAN: begin
                    if (match) begin
                        r_res_idx <= r_cmp_idx;
                        r_state   <= S_DONE;
                        case (r_action)
                            ACT_ENROLL: r_res_status <= ST_DUP;
                            ACT_DEACT: begin
                                r_active[r_cmp_idx] <= 1'b0;
                                r_res_status        <= ST_OK;
                            end
                            default: begin
                                r_res_status <= r_active[r_cmp_idx] ? ST_OK : ST_INACTIVE;
                            end
                        endcase
                    end else if (scan_end) begin
                        r_state <= S_DONE;
                        case (r_action)
                            ACT_ENROLL: begin
                                if (r_total >= DEPTH_C) begin
                                    r_res_status <= ST_FULL;
                                end else begin
                                    r_active[r_total[IDX_W-1:0]] <= 1'b1;
                                    r_res_idx    <= r_total[IDX_W-1:0];
                                    r_total      <= r_total + 1'b1;
                                    r_res_status <= ST_OK;
                                end
                            end
                            default: r_res_status <= ST_NOTFOUND;
                        endcase
                    end else begin
                        r_cmp_idx <= r_rd_idx[IDX_W-1:0];
                        r_rd_vld  <= 1'b1;
                        r_rd_idx  <= r_rd_idx + 1'b1;
                    end
                end
                // load the output register once it is free
                S_DONE: begin
                    if (out_load) begin
                        r_out_status <= r_res_status;
                        r_out_ones   <= r_ones;
                        r_out_idx    <= idx_ext[IDX_OUT_W-1:0];
                        r_out_cnt    <= cnt_ext[CNT_OUT_W-1:0];
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ports
    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_ones_count     = r_out_ones;
    assign o_entry_index    = r_out_idx;
    assign o_enrolled_count = r_out_cnt;

    // checks
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= DEPTH_C)
        else $error("entry total beyond table depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while a request is in progress");

    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_total != $past(r_total)))
            |-> (r_total == CNT_W'($past(r_total) + 1'b1)))
        else $error("entry total changed by other than one");

    a_hit_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && match) |-> (CNT_W'(r_cmp_idx) < r_total))
        else $error("match on an entry outside the table");

    a_ones_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_status == ST_DUP) || (o_status == ST_FULL)
            || (o_status == ST_BADACTION))) |-> (o_ones_count == '0))
        else $error("ones count reported for a request without a response");

endmodule

### src/dtrc_ram.sv
// generic single write, single read ram with registered read data
module dtrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
